/* rtl/hex_rle_stream_decoder_defines.svh */
// Assertion macros shared by the hex run-length decoder RTL.
`ifndef HEX_RLE_STREAM_DECODER_DEFINES_SVH
`define HEX_RLE_STREAM_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define HRSD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("hrsd: property failed");

// Check that a condition never holds outside reset.
`define HRSD_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("hrsd: forbidden condition seen");

`else

`define HRSD_ASSERT(lbl, clk, rstn, prop)
`define HRSD_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

/* rtl/hrsd_pkg.sv */
// Types, constants and the hex digit decoder for the hex run-length decoder.
`default_nettype none

package hrsd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned NibW  = 4;

  // Added to the low seven control bits to get a run's repeat count.
  localparam logic [ByteW-1:0] RunBias = 8'd3;
  localparam logic [ByteW-1:0] LitRepeat = 8'd1;
  localparam logic [ByteW-1:0] MaxRepeat = 8'd130;

  localparam logic [ByteW-1:0] ChZero = 8'h30;  // '0'
  localparam logic [ByteW-1:0] ChNine = 8'h39;  // '9'
  localparam logic [ByteW-1:0] ChUpA  = 8'h41;  // 'A'
  localparam logic [ByteW-1:0] ChUpF  = 8'h46;  // 'F'

  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_RUN  = 2'd1,
    PH_LIT  = 2'd2
  } phase_e;

  typedef struct packed {
    logic            valid;
    logic [NibW-1:0] nibble;
  } hex_t;

  typedef struct packed {
    logic [ByteW-1:0] repeat_count;
    logic [ByteW-1:0] data_byte;
  } result_t;

  typedef struct packed {
    logic valid;  // an item sits in the input register
    logic take;   // that item moves on this cycle
  } item_ctl_t;

  function automatic hex_t hex_decode(input logic [ByteW-1:0] ch);
    hex_t h;
    logic [ByteW-1:0] diff_num;
    logic [ByteW-1:0] diff_alpha;
    diff_num   = ch - ChZero;
    diff_alpha = ch - ChUpA + 8'd10;
    h.valid  = 1'b0;
    h.nibble = '0;
    if (ch >= ChZero && ch <= ChNine) begin
      h.valid  = 1'b1;
      h.nibble = diff_num[NibW-1:0];
    end else if (ch >= ChUpA && ch <= ChUpF) begin
      h.valid  = 1'b1;
      h.nibble = diff_alpha[NibW-1:0];
    end
    return h;
  endfunction

endpackage

`default_nettype wire

/* rtl/hex_rle_stream_decoder.sv */
// Top level of the hex-text run-length decoder with stream ports.
`default_nettype none
`include "hex_rle_stream_decoder_defines.svh"

// Takes one ASCII character per transaction, pairs uppercase hex digits into
// bytes and decodes run-length packets: a control byte with the top bit set
// gives one run (count = low seven bits + 3), otherwise control + 1 literal
// bytes follow, each with count 1. Other characters are skipped; tlast on a
// character returns the decoder to expecting a control byte and drops any
// half byte. Each result passes through the input register, then the result
// register; one character is taken every cycle unless the item held in the
// input register must emit while a stalled result register still holds one.

module hex_rle_stream_decoder import hrsd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  wire logic        s_axis_tlast,   // last_char
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [7:0] data_byte, [15:8] repeat_count
);

  logic             in_vld_q;
  logic [ByteW-1:0] in_char_q;
  logic             in_last_q;
  logic             out_vld_q, out_vld_d;
  result_t          out_q;

  item_ctl_t ctl;
  logic      emit;
  result_t   result;
  logic      advance;
  logic      s_fire;

  // An item moves on when it emits nothing or the result slot frees up.
  assign advance    = in_vld_q && (!emit || !out_vld_q || m_axis_tready);
  assign ctl.valid  = in_vld_q;
  assign ctl.take   = advance;
  assign s_axis_tready = !in_vld_q || advance;
  assign s_fire     = s_axis_tvalid && s_axis_tready;

  hrsd_decode_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .char_code_i (in_char_q),
    .last_char_i (in_last_q),
    .emit_o      (emit),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance && emit) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.repeat_count, out_q.data_byte};

  `HRSD_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni,
    advance && emit && out_vld_q && !m_axis_tready)
  `HRSD_ASSERT(a_hold_item, clk_i, rst_ni,
    (in_vld_q && !advance) |=> in_vld_q)
  `HRSD_ASSERT(a_accept_loads, clk_i, rst_ni,
    s_fire |=> in_vld_q)

endmodule

`default_nettype wire

/* rtl/hrsd_decode_core.sv */
// Nibble pairing and packet state for the hex run-length decoder.
`default_nettype none
`include "hex_rle_stream_decoder_defines.svh"

module hrsd_decode_core import hrsd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire item_ctl_t        ctl_i,
  input  wire logic [ByteW-1:0] char_code_i,
  input  wire logic             last_char_i,
  output logic                  emit_o,
  output result_t               result_o
);

  logic [NibW-1:0]  high_q, high_d;
  logic             pend_q, pend_d;
  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] lit_q, lit_d;
  logic [ByteW-1:0] run_q, run_d;

  hex_t             hex;
  logic [ByteW-1:0] byte_val;
  logic [ByteW-1:0] lit_dec;

  assign hex      = hex_decode(char_code_i);
  assign byte_val = {high_q, hex.nibble};
  assign lit_dec  = lit_q - 8'd1;

  // Result for the item now in the input register.
  always_comb begin
    emit_o                = 1'b0;
    result_o.data_byte    = byte_val;
    result_o.repeat_count = LitRepeat;
    if (ctl_i.valid && hex.valid && pend_q) begin
      case (phase_q)
        PH_RUN: begin
          emit_o                = 1'b1;
          result_o.repeat_count = run_q;
        end
        PH_LIT: begin
          emit_o = 1'b1;
        end
        default: begin
          emit_o = 1'b0;
        end
      endcase
    end
  end

  // Next state once the item is taken.
  always_comb begin
    high_d  = high_q;
    pend_d  = pend_q;
    phase_d = phase_q;
    lit_d   = lit_q;
    run_d   = run_q;
    if (ctl_i.take && hex.valid) begin
      if (pend_q) begin
        pend_d = 1'b0;
        case (phase_q)
          PH_RUN: begin
            phase_d = PH_CTRL;
          end
          PH_LIT: begin
            lit_d = lit_dec;
            if (lit_dec == '0) begin
              phase_d = PH_CTRL;
            end
          end
          default: begin
            if (byte_val[ByteW-1]) begin
              run_d   = {1'b0, byte_val[ByteW-2:0]} + RunBias;
              phase_d = PH_RUN;
            end else begin
              lit_d   = byte_val + 8'd1;
              phase_d = PH_LIT;
            end
          end
        endcase
      end else begin
        high_d = hex.nibble;
        pend_d = 1'b1;
      end
    end
    // Drop any half byte or open packet at the end of a block.
    if (ctl_i.take && last_char_i) begin
      phase_d = PH_CTRL;
      pend_d  = 1'b0;
      high_d  = '0;
      lit_d   = '0;
      run_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q  <= '0;
      pend_q  <= 1'b0;
      phase_q <= PH_CTRL;
      lit_q   <= '0;
      run_q   <= '0;
    end else begin
      high_q  <= high_d;
      pend_q  <= pend_d;
      phase_q <= phase_d;
      lit_q   <= lit_d;
      run_q   <= run_d;
    end
  end

  `HRSD_ASSERT(a_repeat_range, clk_i, rst_ni,
    emit_o |-> (result_o.repeat_count != '0 && result_o.repeat_count <= MaxRepeat))
  `HRSD_ASSERT(a_last_resets, clk_i, rst_ni,
    (ctl_i.take && last_char_i) |=> (phase_q == PH_CTRL && !pend_q))
  `HRSD_ASSERT_NEVER(a_lit_nonzero, clk_i, rst_ni,
    phase_q == PH_LIT && lit_q == '0)

endmodule

`default_nettype wire
